// File: sv/ifdp_pkg.sv
// shared types, widths, register codes and arithmetic helpers for the fused dot product core
package ifdp_pkg;

   localparam int SAMPLE_W = 16;
   localparam int ACC_W    = 56;
   localparam int COORD_W  = 16;
   localparam int MAX_COMP = 8;
   localparam int CNT_W    = $clog2(MAX_COMP);
   localparam int NCOMP_W  = 4;
   localparam int PROD_W   = 2 * SAMPLE_W;
   localparam int SUM_W    = PROD_W + 2;
   localparam int EXT_W    = ACC_W + 2;
   localparam int ADDR_W   = 5;
   localparam int DATA_W   = 32;

   typedef enum logic [2:0] {
      REG_FIRST_X = 3'd0,
      REG_END_X   = 3'd1,
      REG_FIRST_Y = 3'd2,
      REG_END_Y   = 3'd3,
      REG_FIRST_Z = 3'd4,
      REG_END_Z   = 3'd5,
      REG_NCOMP   = 3'd6,
      REG_COMPLEX = 3'd7
   } reg_idx_type;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic signed [SUM_W-1:0]    sum_type;
   typedef logic signed [ACC_W-1:0]    acc_type;
   typedef logic [COORD_W-1:0]         coord_type;

   typedef struct packed {
      coord_type          first_x;
      coord_type          end_x;
      coord_type          first_y;
      coord_type          end_y;
      coord_type          first_z;
      coord_type          end_z;
      logic [NCOMP_W-1:0] ncomp;
      logic               cplx;
   } cfg_type;

   typedef struct packed {
      sample_type r_re;
      sample_type r_im;
      sample_type u_re;
      sample_type u_im;
      sample_type w_re;
      sample_type w_im;
   } elem_type;

   typedef struct packed {
      sum_type ru_re;
      sum_type ru_im;
      sum_type wu_re;
      sum_type wu_im;
      sum_type rr;
   } sums_type;

   typedef struct packed {
      acc_type ru_re;
      acc_type ru_im;
      acc_type wu_re;
      acc_type wu_im;
      acc_type rr;
   } accs_type;

   typedef struct packed {
      acc_type          ru_re;
      acc_type          ru_im;
      acc_type          wu_re;
      acc_type          wu_im;
      logic [ACC_W-2:0] rr;
      logic             sat;
   } res_type;

   typedef struct packed {
      acc_type value;
      logic    clip;
   } sat_res_type;

   // a*b +/- c*d, exact
   function automatic sum_type pair_sum(input sample_type a, input sample_type b,
                                        input sample_type c, input sample_type d,
                                        input logic neg);
      prod_type p;
      prod_type q;
      sum_type  ps;
      sum_type  qs;
      p  = a * b;
      q  = c * d;
      ps = {{(SUM_W-PROD_W){p[PROD_W-1]}}, p};
      qs = {{(SUM_W-PROD_W){q[PROD_W-1]}}, q};
      return neg ? sum_type'(ps - qs) : sum_type'(ps + qs);
   endfunction

   // exact add, then clip to the signed accumulator range
   function automatic sat_res_type sat_add(input acc_type acc, input sum_type t);
      logic signed [EXT_W-1:0] s;
      sat_res_type             r;
      s = {{(EXT_W-ACC_W){acc[ACC_W-1]}}, acc} + {{(EXT_W-SUM_W){t[SUM_W-1]}}, t};
      // overflow when the three top bits disagree
      r.clip = !((s[EXT_W-1:ACC_W-1] == '0) || (s[EXT_W-1:ACC_W-1] == '1));
      if (r.clip) begin
         r.value = s[EXT_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         r.value = s[ACC_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: sv/ifdp_csr.sv
// configuration registers behind the apb-style port
module ifdp_csr import ifdp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type idx;
   logic        wr_en;

   assign pready = 1'b1;
   assign idx    = reg_idx_type'(paddr[ADDR_W-1:2]);
   assign wr_en  = psel && penable && pwrite && pready;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_FIRST_X: cfg_in.first_x = pwdata[COORD_W-1:0];
            REG_END_X:   cfg_in.end_x   = pwdata[COORD_W-1:0];
            REG_FIRST_Y: cfg_in.first_y = pwdata[COORD_W-1:0];
            REG_END_Y:   cfg_in.end_y   = pwdata[COORD_W-1:0];
            REG_FIRST_Z: cfg_in.first_z = pwdata[COORD_W-1:0];
            REG_END_Z:   cfg_in.end_z   = pwdata[COORD_W-1:0];
            REG_NCOMP:   cfg_in.ncomp   = pwdata[NCOMP_W-1:0];
            REG_COMPLEX: cfg_in.cplx    = pwdata[0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_FIRST_X: prdata = DATA_W'(cfg_ff.first_x);
         REG_END_X:   prdata = DATA_W'(cfg_ff.end_x);
         REG_FIRST_Y: prdata = DATA_W'(cfg_ff.first_y);
         REG_END_Y:   prdata = DATA_W'(cfg_ff.end_y);
         REG_FIRST_Z: prdata = DATA_W'(cfg_ff.first_z);
         REG_END_Z:   prdata = DATA_W'(cfg_ff.end_z);
         REG_NCOMP:   prdata = DATA_W'(cfg_ff.ncomp);
         REG_COMPLEX: prdata = DATA_W'(cfg_ff.cplx);
         default:     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_x <= '0;
         cfg_ff.end_x   <= '1;
         cfg_ff.first_y <= '0;
         cfg_ff.end_y   <= '1;
         cfg_ff.first_z <= '0;
         cfg_ff.end_z   <= '1;
         cfg_ff.ncomp   <= NCOMP_W'(1);
         cfg_ff.cplx    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: sv/ifdp_pos.sv
// grid position tracking and interior window test
module ifdp_pos import ifdp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    accept,
   input  logic    row_end,
   input  logic    plane_end,
   input  logic    stream_end,
   output logic    interior
);

   logic [CNT_W-1:0]   comp_ff;
   logic [CNT_W-1:0]   comp_in;
   coord_type          pos_x_ff;
   coord_type          pos_x_in;
   coord_type          pos_y_ff;
   coord_type          pos_y_in;
   coord_type          pos_z_ff;
   coord_type          pos_z_in;
   logic [NCOMP_W-1:0] ncomp;
   logic [NCOMP_W-1:0] comp_next;

   // zero counts as one, oversize counts as the maximum
   always_comb begin
      if (cfg.ncomp == '0) begin
         ncomp = NCOMP_W'(1);
      end else if (cfg.ncomp > NCOMP_W'(MAX_COMP)) begin
         ncomp = NCOMP_W'(MAX_COMP);
      end else begin
         ncomp = cfg.ncomp;
      end
   end

   assign comp_next = NCOMP_W'(comp_ff) + NCOMP_W'(1);

   assign interior = (pos_x_ff >= cfg.first_x) && (pos_x_ff < cfg.end_x) &&
                     (pos_y_ff >= cfg.first_y) && (pos_y_ff < cfg.end_y) &&
                     (pos_z_ff >= cfg.first_z) && (pos_z_ff < cfg.end_z);

   always_comb begin
      comp_in  = comp_ff;
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      pos_z_in = pos_z_ff;
      if (accept) begin
         if (stream_end) begin
            comp_in  = '0;
            pos_x_in = '0;
            pos_y_in = '0;
            pos_z_in = '0;
         end else if (row_end || plane_end) begin
            comp_in  = '0;
            pos_x_in = '0;
            if (plane_end) begin
               pos_y_in = '0;
               pos_z_in = pos_z_ff + coord_type'(1);
            end else begin
               pos_y_in = pos_y_ff + coord_type'(1);
            end
         end else if (comp_next >= ncomp) begin
            comp_in  = '0;
            pos_x_in = pos_x_ff + coord_type'(1);
         end else begin
            comp_in = comp_next[CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         comp_ff  <= '0;
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         pos_z_ff <= '0;
      end else begin
         comp_ff  <= comp_in;
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         pos_z_ff <= pos_z_in;
      end
   end

endmodule

// File: sv/ifdp_dot.sv
// sample register, product register and saturating accumulators
module ifdp_dot import ifdp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     accept,
   input  elem_type in_elem,
   input  logic     in_interior,
   input  logic     in_complex,
   input  logic     in_stream_end,
   input  logic     out_free,
   output logic     in_stall,
   output logic     res_load,
   output res_type  res
);

   elem_type    masked;
   elem_type    a_elem_ff;
   logic        a_end_ff;
   logic        a_vld_ff;
   logic        a_vld_in;
   sums_type    sums;
   sums_type    b_sums_ff;
   logic        b_end_ff;
   logic        b_vld_ff;
   logic        b_vld_in;
   accs_type    acc_ff;
   accs_type    acc_in;
   logic        sat_ff;
   logic        sat_in;
   sat_res_type n_ru_re;
   sat_res_type n_ru_im;
   sat_res_type n_wu_re;
   sat_res_type n_wu_im;
   sat_res_type n_rr;
   logic        clip_any;
   logic        move_a;
   logic        move_b;

   // ghost items and unused imaginary parts enter as zeros
   always_comb begin
      masked = in_elem;
      if (!in_interior) begin
         masked = '0;
      end else if (!in_complex) begin
         masked.r_im = '0;
         masked.u_im = '0;
         masked.w_im = '0;
      end
   end

   // only a stream end item waits for the result register
   assign move_b   = b_vld_ff && (!b_end_ff || out_free);
   assign move_a   = a_vld_ff && (!b_vld_ff || move_b);
   assign in_stall = a_vld_ff && !move_a;
   assign res_load = move_b && b_end_ff;

   assign a_vld_in = accept ? 1'b1 : (move_a ? 1'b0 : a_vld_ff);
   assign b_vld_in = move_a ? 1'b1 : (move_b ? 1'b0 : b_vld_ff);

   always_comb begin
      sums.ru_re = pair_sum(a_elem_ff.r_re, a_elem_ff.u_re, a_elem_ff.r_im, a_elem_ff.u_im, 1'b0);
      sums.ru_im = pair_sum(a_elem_ff.r_re, a_elem_ff.u_im, a_elem_ff.r_im, a_elem_ff.u_re, 1'b1);
      sums.wu_re = pair_sum(a_elem_ff.w_re, a_elem_ff.u_re, a_elem_ff.w_im, a_elem_ff.u_im, 1'b0);
      sums.wu_im = pair_sum(a_elem_ff.w_re, a_elem_ff.u_im, a_elem_ff.w_im, a_elem_ff.u_re, 1'b1);
      sums.rr    = pair_sum(a_elem_ff.r_re, a_elem_ff.r_re, a_elem_ff.r_im, a_elem_ff.r_im, 1'b0);
   end

   always_comb begin
      n_ru_re  = sat_add(acc_ff.ru_re, b_sums_ff.ru_re);
      n_ru_im  = sat_add(acc_ff.ru_im, b_sums_ff.ru_im);
      n_wu_re  = sat_add(acc_ff.wu_re, b_sums_ff.wu_re);
      n_wu_im  = sat_add(acc_ff.wu_im, b_sums_ff.wu_im);
      n_rr     = sat_add(acc_ff.rr, b_sums_ff.rr);
      clip_any = n_ru_re.clip | n_ru_im.clip | n_wu_re.clip | n_wu_im.clip | n_rr.clip;

      res.ru_re = n_ru_re.value;
      res.ru_im = n_ru_im.value;
      res.wu_re = n_wu_re.value;
      res.wu_im = n_wu_im.value;
      res.rr    = n_rr.value[ACC_W-2:0];
      res.sat   = sat_ff | clip_any;

      acc_in = acc_ff;
      sat_in = sat_ff;
      if (move_b) begin
         if (b_end_ff) begin
            acc_in = '0;
            sat_in = 1'b0;
         end else begin
            acc_in.ru_re = n_ru_re.value;
            acc_in.ru_im = n_ru_im.value;
            acc_in.wu_re = n_wu_re.value;
            acc_in.wu_im = n_wu_im.value;
            acc_in.rr    = n_rr.value;
            sat_in       = sat_ff | clip_any;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_elem_ff <= masked;
         a_end_ff  <= in_stream_end;
      end
      if (move_a) begin
         b_sums_ff <= sums;
         b_end_ff  <= a_end_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         acc_ff   <= '0;
         sat_ff   <= 1'b0;
      end else begin
         a_vld_ff <= a_vld_in;
         b_vld_ff <= b_vld_in;
         acc_ff   <= acc_in;
         sat_ff   <= sat_in;
      end
   end

endmodule

// File: sv/interior_fused_dot_products_core.sv
// top level of the interior fused dot product core
// Takes one grid element per clock while not stalled, ghost cells included, and sums
// conj(r)u, conj(w)u and conj(r)r over the elements whose pixel lies in the configured
// interior window. A result shows on rsp_valid once its stream_end item has passed the
// sample register and then the product register, where the accumulator update loads
// the result register. The accumulators are the only loop, so a new item is taken
// every cycle unless the input stalls. Input stalls only while a finished result is
// held by rsp_stall and the next stream end reaches the accumulators.
// Configuration registers sit at byte address 4*index and must be written while idle.
module interior_fused_dot_products_core import ifdp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [15:0]  req_r_re,
   input  logic signed [15:0]  req_r_im,
   input  logic signed [15:0]  req_u_re,
   input  logic signed [15:0]  req_u_im,
   input  logic signed [15:0]  req_w_re,
   input  logic signed [15:0]  req_w_im,
   input  logic                req_row_end,
   input  logic                req_plane_end,
   input  logic                req_stream_end,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [55:0]  rsp_ru_re,
   output logic signed [55:0]  rsp_ru_im,
   output logic signed [55:0]  rsp_wu_re,
   output logic signed [55:0]  rsp_wu_im,
   output logic [54:0]         rsp_rr_sum,
   output logic                rsp_saturated,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [ADDR_W-1:0]   paddr,
   input  logic [DATA_W-1:0]   pwdata,
   output logic [DATA_W-1:0]   prdata,
   output logic                pready
);

   cfg_type  cfg;
   elem_type in_elem;
   logic     interior;
   logic     accept;
   logic     out_free;
   logic     res_load;
   res_type  res;
   res_type  res_ff;
   logic     rsp_valid_ff;
   logic     rsp_valid_in;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign in_elem.r_re = req_r_re;
   assign in_elem.r_im = req_r_im;
   assign in_elem.u_re = req_u_re;
   assign in_elem.u_im = req_u_im;
   assign in_elem.w_re = req_w_re;
   assign in_elem.w_im = req_w_im;

   ifdp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ifdp_pos u_pos (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .accept     (accept),
      .row_end    (req_row_end),
      .plane_end  (req_plane_end),
      .stream_end (req_stream_end),
      .interior   (interior)
   );

   ifdp_dot u_dot (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .in_elem       (in_elem),
      .in_interior   (interior),
      .in_complex    (cfg.cplx),
      .in_stream_end (req_stream_end),
      .out_free      (out_free),
      .in_stall      (req_stall),
      .res_load      (res_load),
      .res           (res)
   );

   assign rsp_valid_in = res_load ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (res_load) begin
         res_ff <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ru_re     = res_ff.ru_re;
   assign rsp_ru_im     = res_ff.ru_im;
   assign rsp_wu_re     = res_ff.wu_re;
   assign rsp_wu_im     = res_ff.wu_im;
   assign rsp_rr_sum    = res_ff.rr;
   assign rsp_saturated = res_ff.sat;

endmodule

// File: bench/tb.sv
// self-checking testbench for the interior fused dot product core
module tb;
   import ifdp_pkg::*;

   localparam int     RANDOM_ITEMS = 1800;
   localparam int     HOLD_LEN     = 200;
   localparam int     IDLE_LIMIT   = 2000;
   localparam int     PIPE_DRAIN   = 6;
   localparam longint ACC_HI       = (longint'(1) << (ACC_W - 1)) - 1;
   localparam longint ACC_LO       = -ACC_HI - 1;

   logic clock = 1'b0;
   logic reset;

   logic                req_valid;
   logic                req_stall;
   logic signed [15:0]  req_r_re, req_r_im, req_u_re, req_u_im, req_w_re, req_w_im;
   logic                req_row_end, req_plane_end, req_stream_end;
   logic                rsp_valid;
   logic                rsp_stall;
   logic signed [55:0]  rsp_ru_re, rsp_ru_im, rsp_wu_re, rsp_wu_im;
   logic [54:0]         rsp_rr_sum;
   logic                rsp_saturated;
   logic                psel, penable, pwrite;
   logic [ADDR_W-1:0]   paddr;
   logic [DATA_W-1:0]   pwdata;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   interior_fused_dot_products_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_r_re(req_r_re), .req_r_im(req_r_im),
      .req_u_re(req_u_re), .req_u_im(req_u_im),
      .req_w_re(req_w_re), .req_w_im(req_w_im),
      .req_row_end(req_row_end), .req_plane_end(req_plane_end),
      .req_stream_end(req_stream_end),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_ru_re(rsp_ru_re), .rsp_ru_im(rsp_ru_im),
      .rsp_wu_re(rsp_wu_re), .rsp_wu_im(rsp_wu_im),
      .rsp_rr_sum(rsp_rr_sum), .rsp_saturated(rsp_saturated),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the configuration registers
   coord_type   cfg_first_x = '0, cfg_end_x = '1;
   coord_type   cfg_first_y = '0, cfg_end_y = '1;
   coord_type   cfg_first_z = '0, cfg_end_z = '1;
   logic [3:0]  cfg_ncomp = 4'd1;
   bit          cfg_cplx = 1'b0;

   // running sums and grid position of the stream in flight
   longint      sum_ru_re = 0, sum_ru_im = 0, sum_wu_re = 0, sum_wu_im = 0, sum_rr = 0;
   bit          clip_seen = 1'b0;
   int          comp_idx = 0;
   coord_type   pos_x = '0, pos_y = '0, pos_z = '0;

   res_type     pending_sums[$];
   int          errors = 0;
   int          idle_cycles = 0;
   int          random_items = 0;
   bit          idle_on = 1'b1;
   int          hold_ticket = 0;

   function automatic void add_clipped(inout longint acc, input longint t);
      longint s;
      s = acc + t;
      if (s > ACC_HI) begin
         acc = ACC_HI;
         clip_seen = 1'b1;
      end else if (s < ACC_LO) begin
         acc = ACC_LO;
         clip_seen = 1'b1;
      end else begin
         acc = s;
      end
   endfunction

   function automatic int pixel_width();
      if (cfg_ncomp == 0) return 1;
      if (cfg_ncomp > MAX_COMP) return MAX_COMP;
      return cfg_ncomp;
   endfunction

   function automatic void fold_element(elem_type e, bit re, bit pe, bit se);
      longint  rr, ri, ur, ui, wr, wi;
      res_type res;
      rr = $signed(e.r_re);
      ri = $signed(e.r_im);
      ur = $signed(e.u_re);
      ui = $signed(e.u_im);
      wr = $signed(e.w_re);
      wi = $signed(e.w_im);
      if (pos_x >= cfg_first_x && pos_x < cfg_end_x && pos_y >= cfg_first_y &&
          pos_y < cfg_end_y && pos_z >= cfg_first_z && pos_z < cfg_end_z) begin
         if (cfg_cplx) begin
            add_clipped(sum_ru_re, rr * ur + ri * ui);
            add_clipped(sum_ru_im, rr * ui - ri * ur);
            add_clipped(sum_wu_re, wr * ur + wi * ui);
            add_clipped(sum_wu_im, wr * ui - wi * ur);
            add_clipped(sum_rr, rr * rr + ri * ri);
         end else begin
            add_clipped(sum_ru_re, rr * ur);
            add_clipped(sum_wu_re, wr * ur);
            add_clipped(sum_rr, rr * rr);
         end
      end
      if (re || pe) begin
         comp_idx = 0;
         pos_x = '0;
         if (pe) begin
            pos_y = '0;
            pos_z = pos_z + 1'b1;
         end else begin
            pos_y = pos_y + 1'b1;
         end
      end else if (comp_idx + 1 >= pixel_width()) begin
         comp_idx = 0;
         pos_x = pos_x + 1'b1;
      end else begin
         comp_idx++;
      end
      if (se) begin
         res.ru_re = sum_ru_re[ACC_W-1:0];
         res.ru_im = sum_ru_im[ACC_W-1:0];
         res.wu_re = sum_wu_re[ACC_W-1:0];
         res.wu_im = sum_wu_im[ACC_W-1:0];
         res.rr    = sum_rr[ACC_W-2:0];
         res.sat   = clip_seen;
         pending_sums.push_back(res);
         sum_ru_re = 0;
         sum_ru_im = 0;
         sum_wu_re = 0;
         sum_wu_im = 0;
         sum_rr = 0;
         clip_seen = 1'b0;
         comp_idx = 0;
         pos_x = '0;
         pos_y = '0;
         pos_z = '0;
      end
   endfunction

   function automatic void check_field(string tag, logic [55:0] want, logic [55:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, tag, want, got);
      end
   endfunction

   // result checker and watchdog
   always @(posedge clock) begin
      res_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_sums.size() == 0) begin
            errors++;
            $display("%0t: result with nothing expected, expected none, actual ru_re %h",
                     $time, rsp_ru_re);
         end else begin
            want = pending_sums.pop_front();
            check_field("ru_re", want.ru_re, rsp_ru_re);
            check_field("ru_im", want.ru_im, rsp_ru_im);
            check_field("wu_re", want.wu_re, rsp_wu_re);
            check_field("wu_im", want.wu_im, rsp_wu_im);
            check_field("rr_sum", 56'(want.rr), 56'(rsp_rr_sum));
            check_field("saturated", 56'(want.sat), 56'(rsp_saturated));
         end
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (psel && penable && pwrite))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL interior_fused_dot_products_core");
         $finish;
      end
   end

   // result side: random stalls, plus a long hold-off on request
   int hold_seen = 0;
   int hold_left = 0;
   always @(negedge clock) begin
      if (hold_ticket != hold_seen) begin
         hold_seen = hold_ticket;
         hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= idle_on && ($urandom_range(99) < 14);
      end
   end

   function automatic sample_type rand_sample();
      case ($urandom_range(7))
         0: return sample_type'(16'h8000);
         1: return sample_type'(16'h7fff);
         2: return '0;
         3: return '1;
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic elem_type rand_elem();
      elem_type e;
      e.r_re = rand_sample();
      e.r_im = rand_sample();
      e.u_re = rand_sample();
      e.u_im = rand_sample();
      e.w_re = rand_sample();
      e.w_im = rand_sample();
      return e;
   endfunction

   function automatic elem_type make_elem(sample_type a, b, c, d, f, g);
      elem_type e;
      e.r_re = a;
      e.r_im = b;
      e.u_re = c;
      e.u_im = d;
      e.w_re = f;
      e.w_im = g;
      return e;
   endfunction

   // called and returns at a falling edge
   task automatic send_elem(elem_type e, bit re, bit pe, bit se);
      if (idle_on && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_r_re       <= e.r_re;
      req_r_im       <= e.r_im;
      req_u_re       <= e.u_re;
      req_u_im       <= e.u_im;
      req_w_re       <= e.w_re;
      req_w_im       <= e.w_im;
      req_row_end    <= re;
      req_plane_end  <= pe;
      req_stream_end <= se;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      fold_element(e, re, pe, se);
      @(negedge clock);
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (pending_sums.size() != 0) @(negedge clock);
      repeat (PIPE_DRAIN) @(negedge clock);
   endtask

   task automatic csr_write(reg_idx_type idx, logic [DATA_W-1:0] v);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= v;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         REG_FIRST_X: cfg_first_x = v[15:0];
         REG_END_X:   cfg_end_x   = v[15:0];
         REG_FIRST_Y: cfg_first_y = v[15:0];
         REG_END_Y:   cfg_end_y   = v[15:0];
         REG_FIRST_Z: cfg_first_z = v[15:0];
         REG_END_Z:   cfg_end_z   = v[15:0];
         REG_NCOMP:   cfg_ncomp   = v[3:0];
         REG_COMPLEX: cfg_cplx    = v[0];
         default: ;
      endcase
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic apply_config(coord_type fx, ex, fy, ey, fz, ez, logic [3:0] nc, logic cx);
      csr_write(REG_FIRST_X, 32'(fx));
      csr_write(REG_END_X, 32'(ex));
      csr_write(REG_FIRST_Y, 32'(fy));
      csr_write(REG_END_Y, 32'(ey));
      csr_write(REG_FIRST_Z, 32'(fz));
      csr_write(REG_END_Z, 32'(ez));
      csr_write(REG_NCOMP, 32'(nc));
      csr_write(REG_COMPLEX, 32'(cx));
   endtask

   task automatic test_real_extremes();
      // reset window: everything is interior, one element per pixel
      send_elem(make_elem(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff),
                0, 0, 0);
      send_elem(make_elem(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000),
                0, 0, 0);
      send_elem(make_elem(16'sh0000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'shffff, 16'sh7fff),
                1, 0, 0);
      send_elem(make_elem(16'shffff, 16'sh0001, 16'sh0001, 16'shffff, 16'sh8000, 16'sh0000),
                1, 1, 0);
      send_elem(make_elem(16'sh7fff, 16'sh0000, 16'sh7fff, 16'sh0000, 16'sh8000, 16'sh0000),
                0, 0, 1);
      // one element stream with every flag set
      send_elem(make_elem(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000),
                1, 1, 1);
   endtask

   task automatic test_complex_extremes();
      drain_pipeline();
      apply_config(0, 16'hffff, 0, 16'hffff, 0, 16'hffff, 4'd1, 1'b1);
      send_elem(make_elem(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000),
                0, 0, 0);
      send_elem(make_elem(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff),
                0, 0, 0);
      send_elem(make_elem(16'sh0000, 16'sh7fff, 16'sh7fff, 16'sh0000, 16'sh7fff, 16'sh8000),
                1, 0, 0);
      send_elem(make_elem(16'shffff, 16'sh0001, 16'sh8000, 16'sh8000, 16'sh0001, 16'shffff),
                0, 0, 1);
      send_elem(make_elem(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff),
                0, 0, 1);
   endtask

   task automatic test_empty_window();
      // empty along x, inverted along y: sums stay zero
      drain_pipeline();
      apply_config(3, 3, 4, 1, 0, 16'hffff, 4'd2, 1'b1);
      send_elem(rand_elem(), 0, 0, 0);
      send_elem(rand_elem(), 1, 0, 0);
      send_elem(rand_elem(), 0, 1, 0);
      send_elem(rand_elem(), 0, 0, 1);
   endtask

   task automatic send_grid(int nx, int ny, int nz, bit broken);
      int  w, total, k, x, y, z, c;
      bit  re, pe, se, row_last;
      w = pixel_width();
      total = nx * ny * nz * w;
      k = 0;
      for (z = 0; z < nz; z++) begin
         for (y = 0; y < ny; y++) begin
            for (x = 0; x < nx; x++) begin
               for (c = 0; c < w; c++) begin
                  k++;
                  if (broken) begin
                     re = $urandom_range(99) < 5;
                     pe = $urandom_range(99) < 3;
                     se = (k == total) || ($urandom_range(99) < 2);
                  end else begin
                     row_last = (x == nx - 1) && (c == w - 1);
                     pe = row_last && (y == ny - 1);
                     re = row_last && (pe ? $urandom_range(1) : 1'b1);
                     se = (k == total);
                  end
                  send_elem(rand_elem(), re, pe, se);
                  random_items++;
               end
            end
         end
      end
   endtask

   function automatic void pick_window(int n, output coord_type f, output coord_type e);
      case ($urandom_range(5))
         0: begin
            f = '0;
            e = '1;
         end
         1: begin
            f = '1;
            e = '0;
         end
         2: begin
            f = coord_type'($urandom);
            e = coord_type'($urandom);
         end
         default: begin
            f = coord_type'($urandom_range(n));
            e = coord_type'($urandom_range(n + 1));
         end
      endcase
   endfunction

   task automatic test_random_grids();
      int         phase, nx, ny, nz;
      coord_type  fx, ex, fy, ey, fz, ez;
      logic [3:0] nc;
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         // a run of phases with no idling on either side
         idle_on = !(phase >= 4 && phase <= 8);
         nx = $urandom_range(1, 5);
         ny = $urandom_range(1, 3);
         nz = $urandom_range(1, 2);
         if ($urandom_range(19) == 0) begin
            nx = 12;
            ny = 4;
         end
         pick_window(nx, fx, ex);
         pick_window(ny, fy, ey);
         pick_window(nz, fz, ez);
         case (phase)
            0: nc = 4'd0;
            1: nc = 4'd15;
            2: nc = 4'd8;
            3: nc = 4'd1;
            default: nc = 4'($urandom_range(15));
         endcase
         drain_pipeline();
         apply_config(fx, ex, fy, ey, fz, ez, nc, 1'($urandom_range(1)));
         repeat ($urandom_range(1, 3)) send_grid(nx, ny, nz, $urandom_range(99) < 15);
         phase++;
      end
      idle_on = 1'b1;
   endtask

   task automatic test_result_backpressure();
      // result side holds off while single element streams keep coming
      drain_pipeline();
      apply_config(0, 16'hffff, 0, 16'hffff, 0, 16'hffff, 4'd1, 1'b1);
      idle_on = 1'b0;
      hold_ticket++;
      repeat (30) send_elem(rand_elem(), $urandom_range(1), $urandom_range(1), 1'b1);
      idle_on = 1'b1;
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_r_re       = '0;
      req_r_im       = '0;
      req_u_re       = '0;
      req_u_im       = '0;
      req_w_re       = '0;
      req_w_im       = '0;
      req_row_end    = 1'b0;
      req_plane_end  = 1'b0;
      req_stream_end = 1'b0;
      rsp_stall      = 1'b0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      test_real_extremes();
      test_complex_extremes();
      test_empty_window();
      test_random_grids();
      test_result_backpressure();

      drain_pipeline();
      repeat (10) @(posedge clock);
      if (errors == 0)
         $display("PASS interior_fused_dot_products_core");
      else
         $display("FAIL interior_fused_dot_products_core");
      $finish;
   end

endmodule

// File: files.f
sv/ifdp_pkg.sv
sv/ifdp_csr.sv
sv/ifdp_pos.sv
sv/ifdp_dot.sv
sv/interior_fused_dot_products_core.sv
bench/tb.sv
